/* hw/rtl/wsmtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmtf_pkg
// Shared sizes, types and helpers for the window stack move-to-front core.
// ----------------------------------------------------------------------------
package wsmtf_pkg;

   localparam int Slots    = 16;
   localparam int SlotW    = $clog2(Slots);
   localparam int ActW     = $clog2(Slots + 1);
   localparam int InSlotW  = 5;
   localparam int OutSlotW = 4;
   localparam int FirstW   = 5;
   localparam int MaskW    = 16;
   localparam int CsrDataW = 16;
   localparam int CsrIdxW  = 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FIRST_APP_SLOT,
      CSR_CLIENT_MASK
   } csr_idx_type;

   typedef struct packed {
      logic             load;
      logic             found;
      logic [SlotW-1:0] slot;
   } cell_ctrl_type;

   function automatic logic gets_notice(input logic [ActW-1:0]   s,
                                        input logic [FirstW-1:0] first,
                                        input logic [MaskW-1:0]  mask);
      logic [OutSlotW-1:0] idx;
      idx = OutSlotW'(s);
      return (int'(s) < Slots) && (int'(s) >= int'(first)) &&
             (int'(s) < MaskW) && mask[idx];
   endfunction

endpackage

/* hw/rtl/wsmtf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmtf_req_if / wsmtf_rsp_if
// Valid/ready channels for raise requests and their results.
// ----------------------------------------------------------------------------
interface wsmtf_req_if;
   logic                         valid;
   logic                         ready;
   logic [wsmtf_pkg::InSlotW-1:0] window_slot;

   modport source (output valid, output window_slot, input ready);
   modport sink   (input valid, input window_slot, output ready);
endinterface

interface wsmtf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic                          changed;
   logic                          deactivate_valid;
   logic [wsmtf_pkg::OutSlotW-1:0] deactivate_slot;
   logic                          activate_valid;
   logic [wsmtf_pkg::OutSlotW-1:0] activate_slot;

   modport source (output valid, output found, output changed,
                   output deactivate_valid, output deactivate_slot,
                   output activate_valid, output activate_slot, input ready);
   modport sink   (input valid, input found, input changed,
                   input deactivate_valid, input deactivate_slot,
                   input activate_valid, input activate_slot, output ready);
endinterface

/* hw/rtl/wsmtf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmtf_cell
// One stacking-order position: holds a slot number, takes its upper
// neighbor's entry once the raised slot was found at or below it.
// ----------------------------------------------------------------------------
module wsmtf_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  wsmtf_pkg::cell_ctrl_type         ctrl,
   input  logic [wsmtf_pkg::SlotW-1:0]      reset_value,
   input  logic                             hit_in,
   input  logic [wsmtf_pkg::SlotW-1:0]      next_entry,
   output logic [wsmtf_pkg::SlotW-1:0]      entry,
   output logic                             hit_out
);

   logic [wsmtf_pkg::SlotW-1:0] entry_ff;
   logic [wsmtf_pkg::SlotW-1:0] entry_in;
   logic                        match;

   assign match   = ctrl.found && (entry_ff == ctrl.slot);
   assign hit_out = hit_in || match;
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= reset_value;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

/* hw/rtl/window_stack_move_to_front_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stack_move_to_front_core
// Move-to-front stacking order of window slots with activation notices.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one slot number per request. A slot below Slots is
//   moved to the front (top cell) of the order and becomes active; other
//   values leave everything unchanged and report found = 0.
//   rsp_chan returns exactly one result per request: found, changed and the
//   deactivate/activate notices filtered by first_app_slot and client_mask.
//   csr_we/csr_index/csr_wdata write the two registers; write only when idle.
// Result and throughput:
//   A result appears in the cycle after its request is accepted. The row of
//   cells compares and shifts every position in the same cycle, so one
//   request is taken per cycle while the result register drains.
// Reset:
//   The order returns to identity, no slot is active, the two registers clear.
// Stall:
//   While rsp_chan.ready is low a held result blocks new requests; the
//   request side is ready again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module window_stack_move_to_front_core (
   input  logic                               clock,
   input  logic                               reset,
   wsmtf_req_if.sink                          req_chan,
   wsmtf_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  wsmtf_pkg::csr_idx_type             csr_index,
   input  logic [wsmtf_pkg::CsrDataW-1:0]     csr_wdata
);

   logic [wsmtf_pkg::FirstW-1:0]   first_app_ff, first_app_in;
   logic [wsmtf_pkg::MaskW-1:0]    mask_ff, mask_in;
   logic [wsmtf_pkg::ActW-1:0]     active_ff, active_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           found_ff, found_in;
   logic                           changed_ff, changed_in;
   logic                           deact_valid_ff, deact_valid_in;
   logic [wsmtf_pkg::OutSlotW-1:0] deact_slot_ff, deact_slot_in;
   logic                           act_valid_ff, act_valid_in;
   logic [wsmtf_pkg::OutSlotW-1:0] act_slot_ff, act_slot_in;

   logic                           accept;
   logic                           found;
   logic                           changed;
   logic [wsmtf_pkg::ActW-1:0]     req_slot;
   wsmtf_pkg::cell_ctrl_type       ctrl;

   logic [wsmtf_pkg::Slots:0]      hit_chain;
   logic [wsmtf_pkg::SlotW-1:0]    entry [wsmtf_pkg::Slots];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign found          = int'(req_chan.window_slot) < wsmtf_pkg::Slots;
   assign req_slot       = wsmtf_pkg::ActW'(req_chan.window_slot);
   assign changed        = found && (int'(active_ff) != int'(req_chan.window_slot));

   assign ctrl.load  = accept;
   assign ctrl.found = found;
   assign ctrl.slot  = wsmtf_pkg::SlotW'(req_chan.window_slot);

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < wsmtf_pkg::Slots; i++) begin : g_cell
      logic [wsmtf_pkg::SlotW-1:0] next_entry;
      if (i == wsmtf_pkg::Slots - 1) begin : g_top
         assign next_entry = ctrl.slot;
      end else begin : g_mid
         assign next_entry = entry[i+1];
      end
      wsmtf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .reset_value (wsmtf_pkg::SlotW'(i)),
         .hit_in      (hit_chain[i]),
         .next_entry  (next_entry),
         .entry       (entry[i]),
         .hit_out     (hit_chain[i+1])
      );
   end

   always_comb begin
      first_app_in = first_app_ff;
      mask_in      = mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            wsmtf_pkg::CSR_FIRST_APP_SLOT: begin
               first_app_in = csr_wdata[wsmtf_pkg::FirstW-1:0];
            end
            wsmtf_pkg::CSR_CLIENT_MASK: begin
               mask_in = csr_wdata[wsmtf_pkg::MaskW-1:0];
            end
            default: begin
               first_app_in = first_app_ff;
            end
         endcase
      end
   end

   always_comb begin
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      found_in       = found_ff;
      changed_in     = changed_ff;
      deact_valid_in = deact_valid_ff;
      deact_slot_in  = deact_slot_ff;
      act_valid_in   = act_valid_ff;
      act_slot_in    = act_slot_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         found_in       = found;
         changed_in     = changed;
         deact_valid_in = changed && wsmtf_pkg::gets_notice(active_ff, first_app_ff, mask_ff);
         act_valid_in   = changed && wsmtf_pkg::gets_notice(req_slot, first_app_ff, mask_ff);
         deact_slot_in  = deact_valid_in ? wsmtf_pkg::OutSlotW'(active_ff) : '0;
         act_slot_in    = act_valid_in ? wsmtf_pkg::OutSlotW'(req_chan.window_slot) : '0;
         if (found) begin
            active_in = req_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_app_ff <= '0;
         mask_ff      <= '0;
         active_ff    <= wsmtf_pkg::ActW'(wsmtf_pkg::Slots);
         rsp_valid_ff <= 1'b0;
      end else begin
         first_app_ff <= first_app_in;
         mask_ff      <= mask_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff       <= found_in;
      changed_ff     <= changed_in;
      deact_valid_ff <= deact_valid_in;
      deact_slot_ff  <= deact_slot_in;
      act_valid_ff   <= act_valid_in;
      act_slot_ff    <= act_slot_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.found            = found_ff;
   assign rsp_chan.changed          = changed_ff;
   assign rsp_chan.deactivate_valid = deact_valid_ff;
   assign rsp_chan.deactivate_slot  = deact_slot_ff;
   assign rsp_chan.activate_valid   = act_valid_ff;
   assign rsp_chan.activate_slot    = act_slot_ff;

   a_front_is_raised: assert property (@(posedge clock) disable iff (reset)
      accept && found |=> entry[wsmtf_pkg::Slots-1] == $past(ctrl.slot))
      else $error("raised slot not at front");

   a_active_follows: assert property (@(posedge clock) disable iff (reset)
      accept && found |=> active_ff == $past(req_slot))
      else $error("active slot not updated");

   a_notice_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (deact_valid_ff || act_valid_ff) |-> changed_ff && found_ff)
      else $error("notice without change");

   a_miss_keeps_active: assert property (@(posedge clock) disable iff (reset)
      accept && !found |=> $stable(active_ff))
      else $error("miss altered active slot");

   a_found_slot_in_order: assert property (@(posedge clock) disable iff (reset)
      accept && found |-> hit_chain[wsmtf_pkg::Slots])
      else $error("valid slot missing from order");

endmodule

/* bench/tb_window_stack_move_to_front_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_stack_move_to_front_core
// Self-checking bench for the window stack move-to-front core.
// Raise requests go in on req_chan. A scoreboard keeps its own copy of the
// stacking order, the active slot and both registers, and predicts every
// result: found, changed and the filtered notices. Each result on rsp_chan
// is checked in order against the prediction. The run starts with directed
// requests and then covers several register settings with random requests,
// random idling on both sides, one long output stall and a drain per phase.
// ----------------------------------------------------------------------------
module tb_window_stack_move_to_front_core;

   localparam int Slots    = wsmtf_pkg::Slots;
   localparam int SlotW    = wsmtf_pkg::SlotW;
   localparam int ActW     = wsmtf_pkg::ActW;
   localparam int InSlotW  = wsmtf_pkg::InSlotW;
   localparam int OutSlotW = wsmtf_pkg::OutSlotW;
   localparam int FirstW   = wsmtf_pkg::FirstW;
   localparam int MaskW    = wsmtf_pkg::MaskW;
   localparam int CsrDataW = wsmtf_pkg::CsrDataW;

   localparam int StallLimit  = 2000;
   localparam int HoldCycles  = 80;
   localparam int PhaseItems  = 160;
   localparam int Phases      = 8;

   typedef struct packed {
      logic                found;
      logic                changed;
      logic                deact_valid;
      logic [OutSlotW-1:0] deact_slot;
      logic                act_valid;
      logic [OutSlotW-1:0] act_slot;
   } raise_result_type;

   class raise_scoreboard_type;
      logic [SlotW-1:0]  order [Slots];
      logic [ActW-1:0]   active;
      logic [FirstW-1:0] first_app;
      logic [MaskW-1:0]  mask;
      raise_result_type  expected_q [$];
      int errors;
      int requests;
      int results_seen;
      int not_found_count;
      int reraise_count;
      int notice_count;
      int config_writes;

      function new();
         for (int i = 0; i < Slots; i++) order[i] = SlotW'(i);
         active    = ActW'(Slots);
         first_app = '0;
         mask      = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit notice_allowed(int s);
         if (s >= Slots || s >= MaskW || s < int'(first_app)) return 1'b0;
         return mask[s];
      endfunction

      function void write_reg(wsmtf_pkg::csr_idx_type idx, logic [CsrDataW-1:0] data);
         config_writes++;
         case (idx)
            wsmtf_pkg::CSR_FIRST_APP_SLOT: first_app = data[FirstW-1:0];
            wsmtf_pkg::CSR_CLIENT_MASK:    mask = data[MaskW-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [InSlotW-1:0] s);
         raise_result_type r;
         int pos;
         int prev;
         r    = '0;
         pos  = Slots;
         prev = int'(active);
         requests++;
         for (int i = 0; i < Slots; i++)
            if (pos == Slots && int'(order[i]) == int'(s)) pos = i;
         if (pos < Slots) begin
            for (int i = pos; i < Slots - 1; i++) order[i] = order[i + 1];
            order[Slots - 1] = s[SlotW-1:0];
            active = ActW'(s);
            r.found = 1'b1;
            if (prev != int'(s)) begin
               r.changed = 1'b1;
               if (notice_allowed(prev)) begin
                  r.deact_valid = 1'b1;
                  r.deact_slot  = OutSlotW'(prev);
                  notice_count++;
               end
               if (notice_allowed(int'(s))) begin
                  r.act_valid = 1'b1;
                  r.act_slot  = OutSlotW'(s);
                  notice_count++;
               end
            end else begin
               reraise_count++;
            end
         end else begin
            not_found_count++;
         end
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      endtask

      task check_result(raise_result_type got);
         raise_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no request pending", 1, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.found !== want.found)
               report_mismatch("found", got.found, want.found);
            if (got.changed !== want.changed)
               report_mismatch("changed", got.changed, want.changed);
            if (got.deact_valid !== want.deact_valid)
               report_mismatch("deactivate_valid", got.deact_valid, want.deact_valid);
            if (got.deact_slot !== want.deact_slot)
               report_mismatch("deactivate_slot", got.deact_slot, want.deact_slot);
            if (got.act_valid !== want.act_valid)
               report_mismatch("activate_valid", got.act_valid, want.act_valid);
            if (got.act_slot !== want.act_slot)
               report_mismatch("activate_slot", got.act_slot, want.act_slot);
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   wsmtf_pkg::csr_idx_type csr_index;
   logic [CsrDataW-1:0]    csr_wdata;

   wsmtf_req_if req_chan ();
   wsmtf_rsp_if rsp_chan ();

   raise_scoreboard_type sb = new();

   bit idle_on;
   bit hold_req;
   bit hold_taken;
   int stall_cycles;

   window_stack_move_to_front_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = wsmtf_pkg::CSR_FIRST_APP_SLOT;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.window_slot = '0;
      rsp_chan.ready       = 1'b0;
      idle_on              = 1'b1;
      hold_req             = 1'b0;
      hold_taken           = 1'b0;
      stall_cycles         = 0;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      raise_result_type got;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.window_slot);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.found       = rsp_chan.found;
            got.changed     = rsp_chan.changed;
            got.deact_valid = rsp_chan.deactivate_valid;
            got.deact_slot  = rsp_chan.deactivate_slot;
            got.act_valid   = rsp_chan.activate_valid;
            got.act_slot    = rsp_chan.activate_slot;
            sb.check_result(got);
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // result receiver, with one long hold-off on request
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_chan.ready <= 1'b0;
            for (hold = 0; hold < HoldCycles; hold++) @(posedge clock);
         end else begin
            rsp_chan.ready <= !(idle_on && $urandom_range(99) < 24);
         end
      end
   end

   task send_request(input logic [InSlotW-1:0] s);
      while (idle_on && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.window_slot <= s;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   task write_regs(input int first, input logic [MaskW-1:0] m);
      csr_we    <= 1'b1;
      csr_index <= wsmtf_pkg::CSR_FIRST_APP_SLOT;
      csr_wdata <= CsrDataW'(($urandom() & 32'hFFE0) | (first & 32'h1F));
      @(posedge clock);
      csr_index <= wsmtf_pkg::CSR_CLIENT_MASK;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [InSlotW-1:0] pick_slot();
      int r;
      r = $urandom_range(99);
      if (r < 10) return InSlotW'($urandom_range(31, Slots));
      if (r < 25 && sb.active < Slots) return InSlotW'(sb.active);
      if (r < 45) return InSlotW'(sb.order[$urandom_range(Slots - 1, Slots - 3)]);
      return InSlotW'($urandom_range(Slots - 1));
   endfunction

   initial begin
      int first_sel [Phases];
      logic [MaskW-1:0] mask_sel [Phases];
      logic [InSlotW-1:0] directed_a [$];
      logic [InSlotW-1:0] directed_b [$];
      logic [InSlotW-1:0] directed_c [$];

      first_sel = '{0, 0, 1, 15, 16, 31, 0, 0};
      mask_sel  = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'h5555, 16'h0000};
      first_sel[6] = $urandom_range(16);
      first_sel[7] = $urandom_range(31);
      mask_sel[1]  = MaskW'($urandom());
      mask_sel[7]  = MaskW'($urandom());

      // reset registers: not found, first raise with no active slot, re-raise
      directed_a = '{5'd16, 5'd31, 5'd3, 5'd3, 5'd7};
      // notices on, slots below first_app_slot get none
      directed_b = '{5'd0, 5'd1, 5'd2, 5'd15, 5'd15, 5'd0, 5'd20,
                     5'd15, 5'd9, 5'd4, 5'd31, 5'd5};
      // first_app_slot at Slots: no notices at all
      directed_c = '{5'd6, 5'd12, 5'd6, 5'd0, 5'd15};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_a[i]) send_request(directed_a[i]);
      wait_for_results();
      write_regs(2, 16'hFFFF);
      foreach (directed_b[i]) send_request(directed_b[i]);
      wait_for_results();
      write_regs(Slots, MaskW'($urandom()));
      foreach (directed_c[i]) send_request(directed_c[i]);

      for (int p = 0; p < Phases; p++) begin
         wait_for_results();
         write_regs(first_sel[p], mask_sel[p]);
         idle_on = (p != 5);
         if (p == 2) hold_req = 1'b1;
         repeat (PhaseItems) send_request(pick_slot());
      end
      wait_for_results();
      repeat (4) @(posedge clock);

      if (sb.pending() != 0)
         sb.report_mismatch("expected results left over", sb.pending(), 0);
      $display("covered %0d raise requests: %0d not in the order, %0d re-raises, %0d notices",
               sb.requests, sb.not_found_count, sb.reraise_count, sb.notice_count);
      $display("%0d register writes, %0d results checked, one long output stall",
               sb.config_writes, sb.results_seen);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
